FILE: src/cds_pkg.sv
// shared types, codes and reset values for the contactor drive supervisor
// no dependencies; used by cds_cfg, cds_core and contactor_drive_supervisor
`default_nettype none
package cds_pkg;

  localparam int ADDR_W = 5;

  // command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_ON   = 2'd1;
  localparam logic [1:0] CMD_OFF  = 2'd2;

  // event codes
  localparam logic [1:0] EV_NONE    = 2'd0;
  localparam logic [1:0] EV_RECOVER = 2'd1;
  localparam logic [1:0] EV_RAISE   = 2'd2;

  // register indexes
  localparam logic [2:0] REG_POLARITY  = 3'd0;
  localparam logic [2:0] REG_HOLD      = 3'd1;
  localparam logic [2:0] REG_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_ALARM_DLY = 3'd3;
  localparam logic [2:0] REG_CONFIRM   = 3'd4;
  localparam logic [2:0] REG_MIN_PHASE = 3'd5;

  // reset values
  localparam logic        RST_POLARITY  = 1'b1;
  localparam logic [15:0] RST_HOLD      = 16'd100;
  localparam logic [15:0] RST_TIMEOUT   = 16'd1000;
  localparam logic [15:0] RST_ALARM_DLY = 16'd1000;
  localparam logic [15:0] RST_CONFIRM   = 16'd3000;
  localparam logic [15:0] RST_MIN_PHASE = 16'd700;

  typedef struct packed {
    logic        feedback_polarity;
    logic [15:0] hold_time;
    logic [15:0] drive_timeout;
    logic [15:0] alarm_delay;
    logic [15:0] confirm_time;
    logic [15:0] min_phase_level;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  elapsed;
    logic        status_one;
    logic        status_two;
    logic [15:0] phase_a_level;
    logic [15:0] phase_b_level;
    logic [15:0] phase_c_level;
  } in_word_t;

  typedef struct packed {
    logic        coil_drive;
    logic        coil_power;
    logic        feedback_match;
    logic [1:0]  event_res;
    logic        leak_protect;
    logic        sequence_busy;
    logic [15:0] activation_count;
    logic [15:0] mismatch_time;
  } out_word_t;

  // 16-bit add of an 8-bit step, saturating at all ones
  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

endpackage
`default_nettype wire

FILE: src/cds_cfg.sv
// configuration register file behind the apb-style port
// depends on cds_pkg for register indexes, reset values and cfg_t
`default_nettype none
module cds_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [cds_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]              pwdata,
  output logic      [31:0]              prdata,
  output cds_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [2:0] idx;

  assign idx   = paddr[4:2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.feedback_polarity <= cds_pkg::RST_POLARITY;
      cfg.hold_time         <= cds_pkg::RST_HOLD;
      cfg.drive_timeout     <= cds_pkg::RST_TIMEOUT;
      cfg.alarm_delay       <= cds_pkg::RST_ALARM_DLY;
      cfg.confirm_time      <= cds_pkg::RST_CONFIRM;
      cfg.min_phase_level   <= cds_pkg::RST_MIN_PHASE;
    end else if (wr_en) begin
      case (idx)
        cds_pkg::REG_POLARITY:  cfg.feedback_polarity <= pwdata[0];
        cds_pkg::REG_HOLD:      cfg.hold_time         <= pwdata[15:0];
        cds_pkg::REG_TIMEOUT:   cfg.drive_timeout     <= pwdata[15:0];
        cds_pkg::REG_ALARM_DLY: cfg.alarm_delay       <= pwdata[15:0];
        cds_pkg::REG_CONFIRM:   cfg.confirm_time      <= pwdata[15:0];
        cds_pkg::REG_MIN_PHASE: cfg.min_phase_level   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cds_pkg::REG_POLARITY:  prdata = {31'd0, cfg.feedback_polarity};
      cds_pkg::REG_HOLD:      prdata = {16'd0, cfg.hold_time};
      cds_pkg::REG_TIMEOUT:   prdata = {16'd0, cfg.drive_timeout};
      cds_pkg::REG_ALARM_DLY: prdata = {16'd0, cfg.alarm_delay};
      cds_pkg::REG_CONFIRM:   prdata = {16'd0, cfg.confirm_time};
      cds_pkg::REG_MIN_PHASE: prdata = {16'd0, cfg.min_phase_level};
      default:                prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

FILE: src/cds_core.sv
// supervisor state and its single-pass update for one registered input word
// depends on cds_pkg for cfg_t, in_word_t, out_word_t, codes and sat_add16
`default_nettype none
module cds_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              fire,
  input  wire cds_pkg::in_word_t word,
  input  wire cds_pkg::cfg_t     cfg,
  output cds_pkg::out_word_t     result
);

  localparam logic [1:0] STEP_START = 2'd0;
  localparam logic [1:0] STEP_WAIT  = 2'd1;
  localparam logic [1:0] STEP_END   = 2'd2;

  logic        busy_flag, busy_flag_next;
  logic [1:0]  phase_step, phase_step_next;
  logic        want_closed, want_closed_next;
  logic [15:0] seq_timer, seq_timer_next;
  logic        feedback_reg, feedback_reg_next;
  logic [15:0] fault_timer, fault_timer_next;
  logic        alarm_flag, alarm_flag_next;
  logic [15:0] act_counter, act_counter_next;
  logic [15:0] confirm_timer, confirm_timer_next;
  logic        coil_reg, coil_reg_next;
  logic        power_reg, power_reg_next;
  logic        leak_reg, leak_reg_next;

  logic [1:0]  ev;
  logic [15:0] seq_sum;
  logic [15:0] fault_sum;
  logic        phase_low;

  always_comb begin
    busy_flag_next     = busy_flag;
    phase_step_next    = phase_step;
    want_closed_next   = want_closed;
    seq_timer_next     = seq_timer;
    feedback_reg_next  = feedback_reg;
    fault_timer_next   = fault_timer;
    alarm_flag_next    = alarm_flag;
    act_counter_next   = act_counter;
    confirm_timer_next = confirm_timer;
    coil_reg_next      = coil_reg;
    power_reg_next     = power_reg;
    leak_reg_next      = leak_reg;
    ev                 = cds_pkg::EV_NONE;
    seq_sum            = cds_pkg::sat_add16(seq_timer, word.elapsed);
    fault_sum          = fault_timer + {8'd0, word.elapsed};
    phase_low          = (word.phase_a_level < cfg.min_phase_level) ||
                         (word.phase_b_level < cfg.min_phase_level) ||
                         (word.phase_c_level < cfg.min_phase_level);

    case (word.cmd)
      cds_pkg::CMD_ON: begin
        phase_step_next  = STEP_START;
        want_closed_next = 1'b1;
        act_counter_next = act_counter + 16'd1;
        busy_flag_next   = 1'b1;
      end
      cds_pkg::CMD_OFF: begin
        phase_step_next  = STEP_START;
        want_closed_next = 1'b0;
        busy_flag_next   = 1'b1;
      end
      default: begin
        // sense: a split reading forces a mismatch only while idle
        if (word.status_one == word.status_two) begin
          feedback_reg_next = (word.status_one == cfg.feedback_polarity);
        end else if (!busy_flag) begin
          feedback_reg_next = !want_closed;
        end

        // drive sequence
        if (busy_flag) begin
          case (phase_step)
            STEP_START: begin
              coil_reg_next = want_closed;
              if (want_closed) begin
                power_reg_next = 1'b1;
              end
              seq_timer_next  = 16'd0;
              phase_step_next = STEP_WAIT;
            end
            STEP_WAIT: begin
              if ((want_closed == feedback_reg_next) && (seq_timer >= cfg.hold_time)) begin
                phase_step_next = STEP_END;
              end else begin
                seq_timer_next = seq_sum;
                if (seq_sum > cfg.drive_timeout) begin
                  phase_step_next = STEP_END;
                end
              end
            end
            default: begin
              power_reg_next = 1'b0;
              busy_flag_next = 1'b0;
            end
          endcase
        end

        // supervision
        if (want_closed == feedback_reg_next) begin
          fault_timer_next = 16'd0;
          if (alarm_flag) begin
            alarm_flag_next = 1'b0;
            ev              = cds_pkg::EV_RECOVER;
          end
        end else if (!alarm_flag) begin
          fault_timer_next = fault_sum;
          if (fault_sum > cfg.alarm_delay) begin
            fault_timer_next = fault_sum + 16'd1;
            alarm_flag_next  = 1'b1;
            ev               = cds_pkg::EV_RAISE;
          end
        end

        // raise confirmation against the confirm counter and phase levels
        if (ev == cds_pkg::EV_RAISE) begin
          if (confirm_timer < cfg.confirm_time) begin
            confirm_timer_next = cds_pkg::sat_add16(confirm_timer, word.elapsed);
            ev                 = cds_pkg::EV_NONE;
          end else begin
            confirm_timer_next = 16'd0;
            if (phase_low) begin
              ev = cds_pkg::EV_NONE;
            end
          end
        end

        if ((ev == cds_pkg::EV_RAISE) && !want_closed) begin
          leak_reg_next = 1'b1;
        end
      end
    endcase

    result.coil_drive       = coil_reg_next;
    result.coil_power       = power_reg_next;
    result.feedback_match   = feedback_reg_next;
    result.event_res        = ev;
    result.leak_protect     = leak_reg_next;
    result.sequence_busy    = busy_flag_next;
    result.activation_count = act_counter_next;
    result.mismatch_time    = fault_timer_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_flag     <= 1'b0;
      phase_step    <= STEP_START;
      want_closed   <= 1'b0;
      seq_timer     <= 16'd0;
      feedback_reg  <= 1'b0;
      fault_timer   <= 16'd0;
      alarm_flag    <= 1'b0;
      act_counter   <= 16'd0;
      confirm_timer <= 16'd0;
      coil_reg      <= 1'b0;
      power_reg     <= 1'b0;
      leak_reg      <= 1'b0;
    end else if (fire) begin
      busy_flag     <= busy_flag_next;
      phase_step    <= phase_step_next;
      want_closed   <= want_closed_next;
      seq_timer     <= seq_timer_next;
      feedback_reg  <= feedback_reg_next;
      fault_timer   <= fault_timer_next;
      alarm_flag    <= alarm_flag_next;
      act_counter   <= act_counter_next;
      confirm_timer <= confirm_timer_next;
      coil_reg      <= coil_reg_next;
      power_reg     <= power_reg_next;
      leak_reg      <= leak_reg_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/contactor_drive_supervisor.sv
// top level: input register, supervisor core, result register, config port
// depends on cds_pkg, cds_cfg and cds_core
//
//   channel  | handshake               | words
//   in       | in_valid / in_stall     | cmd, elapsed, status, phase levels
//   out      | out_valid / out_stall   | coil, power, match, event, counts
//   apb      | psel penable pwrite     | paddr, pwdata, prdata, pready = 1
//
// one word a cycle while the output is not stalled: a word is taken into the input
// register, the core updates its state from it and the result lands in the result
// register, from which it drives the outputs
// a stalled result holds the result register; the input register still takes
// one more word, then in_stall rises until the result is taken
// rst clears the supervisor state, the config registers and both valid flags
`default_nettype none
module contactor_drive_supervisor (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 cmd,
  input  wire logic [7:0]                 elapsed,
  input  wire logic                       status_one,
  input  wire logic                       status_two,
  input  wire logic [15:0]                phase_a_level,
  input  wire logic [15:0]                phase_b_level,
  input  wire logic [15:0]                phase_c_level,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic                            coil_drive,
  output logic                            coil_power,
  output logic                            feedback_match,
  output logic [1:0]                      event_res,
  output logic                            leak_protect,
  output logic                            sequence_busy,
  output logic [15:0]                     activation_count,
  output logic [15:0]                     mismatch_time,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [cds_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  cds_pkg::cfg_t      cfg;
  cds_pkg::in_word_t  in_word;
  cds_pkg::out_word_t result;
  cds_pkg::out_word_t out_word;

  logic in_reg_valid;
  logic advance;
  logic accept;
  logic fire;

  assign pready   = 1'b1;
  assign advance  = !out_valid || !out_stall;
  assign in_stall = in_reg_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = in_reg_valid && advance;

  cds_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  cds_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .word   (in_word),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      in_reg_valid <= accept || (in_reg_valid && !advance);
      out_valid    <= fire || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_word.cmd           <= cmd;
      in_word.elapsed       <= elapsed;
      in_word.status_one    <= status_one;
      in_word.status_two    <= status_two;
      in_word.phase_a_level <= phase_a_level;
      in_word.phase_b_level <= phase_b_level;
      in_word.phase_c_level <= phase_c_level;
    end
    if (fire) begin
      out_word <= result;
    end
  end

  assign coil_drive       = out_word.coil_drive;
  assign coil_power       = out_word.coil_power;
  assign feedback_match   = out_word.feedback_match;
  assign event_res        = out_word.event_res;
  assign leak_protect     = out_word.leak_protect;
  assign sequence_busy    = out_word.sequence_busy;
  assign activation_count = out_word.activation_count;
  assign mismatch_time    = out_word.mismatch_time;

  // no undefined event code ever leaves the block
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_res != 2'd3))
    else $error("undefined event code on output");

  // coil power is only on inside a drive sequence
  a_power_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && coil_power |-> sequence_busy)
    else $error("coil power without a running sequence");

  // leak protection latches across delivered words
  a_leak_latch: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && leak_protect) ##1 out_valid |-> leak_protect)
    else $error("leak protection dropped");

  // the input register never loses a word while the result side is stalled
  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !advance |=> in_reg_valid)
    else $error("pending word lost under stall");

endmodule
`default_nettype wire

FILE: sim/tb_contactor_drive_supervisor.sv
// testbench for contactor_drive_supervisor: drives command and tick words, predicts each
// result word in step with the accepted input and checks it field by field
// depends on cds_pkg and the contactor_drive_supervisor rtl
`default_nettype none
module tb_contactor_drive_supervisor;

  localparam logic [1:0] CMD_UNDEF = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  cmd = cds_pkg::CMD_TICK;
  logic [7:0]  elapsed = '0;
  logic        status_one = 1'b0;
  logic        status_two = 1'b0;
  logic [15:0] phase_a_level = '0;
  logic [15:0] phase_b_level = '0;
  logic [15:0] phase_c_level = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        coil_drive;
  logic        coil_power;
  logic        feedback_match;
  logic [1:0]  event_res;
  logic        leak_protect;
  logic        sequence_busy;
  logic [15:0] activation_count;
  logic [15:0] mismatch_time;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [cds_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;

  contactor_drive_supervisor i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .elapsed(elapsed), .status_one(status_one), .status_two(status_two),
    .phase_a_level(phase_a_level), .phase_b_level(phase_b_level),
    .phase_c_level(phase_c_level),
    .out_valid(out_valid), .out_stall(out_stall),
    .coil_drive(coil_drive), .coil_power(coil_power), .feedback_match(feedback_match),
    .event_res(event_res), .leak_protect(leak_protect), .sequence_busy(sequence_busy),
    .activation_count(activation_count), .mismatch_time(mismatch_time),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // settings as the supervisor sees them
  logic        cfg_pol = cds_pkg::RST_POLARITY;
  logic [15:0] cfg_hold = cds_pkg::RST_HOLD;
  logic [15:0] cfg_timeout = cds_pkg::RST_TIMEOUT;
  logic [15:0] cfg_alarm_dly = cds_pkg::RST_ALARM_DLY;
  logic [15:0] cfg_confirm = cds_pkg::RST_CONFIRM;
  logic [15:0] cfg_min = cds_pkg::RST_MIN_PHASE;

  // predicted supervisor state
  logic        seq_busy = 1'b0;
  logic [1:0]  seq_phase = 2'd0;
  logic        want_on = 1'b0;
  logic [15:0] seq_time = '0;
  logic        fb_ok = 1'b0;
  logic [15:0] mis_time = '0;
  logic        alarm_on = 1'b0;
  logic [15:0] act_cnt = '0;
  logic [15:0] confirm_acc = '0;
  logic        coil_on = 1'b0;
  logic        power_on = 1'b0;
  logic        leak_on = 1'b0;

  cds_pkg::in_word_t  pending[$];
  cds_pkg::out_word_t due_words[$];
  int        n_taken = 0;
  int        n_bad = 0;
  bit        in_took = 1'b0;
  int        squeeze_left = 0;
  bit        squeeze_done = 1'b0;

  function automatic bit calm();
    return n_taken >= 500 && n_taken < 800;
  endfunction

  function automatic logic [15:0] sat_sum16(input logic [15:0] a, input logic [7:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {9'd0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  task automatic advance_supervisor(input cds_pkg::in_word_t w,
                                    output cds_pkg::out_word_t r);
    logic [1:0] ev;
    ev = cds_pkg::EV_NONE;
    if (w.cmd == cds_pkg::CMD_ON) begin
      seq_phase = 2'd0;
      want_on = 1'b1;
      act_cnt = act_cnt + 16'd1;
      seq_busy = 1'b1;
    end else if (w.cmd == cds_pkg::CMD_OFF) begin
      seq_phase = 2'd0;
      seq_busy = 1'b1;
      want_on = 1'b0;
    end else begin
      // fold status; a split reading only counts while idle
      if (w.status_one == w.status_two) fb_ok = (w.status_one == cfg_pol);
      else if (!seq_busy) fb_ok = !want_on;
      if (seq_busy) begin
        if (seq_phase == 2'd0) begin
          if (want_on) begin
            coil_on = 1'b1;
            power_on = 1'b1;
          end else begin
            coil_on = 1'b0;
          end
          seq_time = '0;
          seq_phase = 2'd1;
        end else if (seq_phase == 2'd1) begin
          if (want_on == fb_ok && seq_time >= cfg_hold) begin
            seq_phase = 2'd2;
          end else begin
            seq_time = sat_sum16(seq_time, w.elapsed);
            if (seq_time > cfg_timeout) seq_phase = 2'd2;
          end
        end else begin
          power_on = 1'b0;
          seq_busy = 1'b0;
        end
      end
      if (want_on == fb_ok) begin
        mis_time = '0;
        if (alarm_on) begin
          alarm_on = 1'b0;
          ev = cds_pkg::EV_RECOVER;
        end
      end else if (!alarm_on) begin
        mis_time = mis_time + 16'(w.elapsed);
        if (mis_time > cfg_alarm_dly) begin
          mis_time = mis_time + 16'd1;
          alarm_on = 1'b1;
          ev = cds_pkg::EV_RAISE;
        end
      end
      if (ev == cds_pkg::EV_RAISE) begin
        if (confirm_acc < cfg_confirm) begin
          confirm_acc = sat_sum16(confirm_acc, w.elapsed);
          ev = cds_pkg::EV_NONE;
        end else begin
          confirm_acc = '0;
          if (w.phase_c_level < cfg_min || w.phase_b_level < cfg_min ||
              w.phase_a_level < cfg_min)
            ev = cds_pkg::EV_NONE;
        end
      end
      if (ev == cds_pkg::EV_RAISE && !want_on) leak_on = 1'b1;
    end
    r.coil_drive = coil_on;
    r.coil_power = power_on;
    r.feedback_match = fb_ok;
    r.event_res = ev;
    r.leak_protect = leak_on;
    r.sequence_busy = seq_busy;
    r.activation_count = act_cnt;
    r.mismatch_time = mis_time;
  endtask

  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      n_bad++;
    end
  endfunction

  // results are checked before the new input word is predicted
  always @(posedge clk) begin : watch
    cds_pkg::out_word_t got;
    cds_pkg::out_word_t want;
    cds_pkg::out_word_t r;
    if (!rst && out_valid && !out_stall) begin
      got = {coil_drive, coil_power, feedback_match, event_res, leak_protect,
             sequence_busy, activation_count, mismatch_time};
      if (due_words.size() == 0) begin
        $error("result word with nothing expected");
        n_bad++;
      end else begin
        want = due_words.pop_front();
        check_field("coil_drive", 16'(want.coil_drive), 16'(got.coil_drive));
        check_field("coil_power", 16'(want.coil_power), 16'(got.coil_power));
        check_field("feedback_match", 16'(want.feedback_match), 16'(got.feedback_match));
        check_field("event_res", 16'(want.event_res), 16'(got.event_res));
        check_field("leak_protect", 16'(want.leak_protect), 16'(got.leak_protect));
        check_field("sequence_busy", 16'(want.sequence_busy), 16'(got.sequence_busy));
        check_field("activation_count", want.activation_count, got.activation_count);
        check_field("mismatch_time", want.mismatch_time, got.mismatch_time);
      end
    end
    in_took = !rst && in_valid && !in_stall;
    if (in_took) begin
      advance_supervisor({cmd, elapsed, status_one, status_two, phase_a_level,
                          phase_b_level, phase_c_level}, r);
      due_words.push_back(r);
      n_taken++;
    end
  end

  always @(negedge clk) begin : send
    cds_pkg::in_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending.size() > 0 && (calm() || $urandom_range(99) >= 9)) begin
        w = pending.pop_front();
        in_valid <= 1'b1;
        cmd <= w.cmd;
        elapsed <= w.elapsed;
        status_one <= w.status_one;
        status_two <= w.status_two;
        phase_a_level <= w.phase_a_level;
        phase_b_level <= w.phase_b_level;
        phase_c_level <= w.phase_c_level;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // one long hold-off lets the block fill up and stall its input
  always @(negedge clk) begin
    if (squeeze_left > 0) begin
      out_stall <= 1'b1;
      squeeze_left--;
    end else if (!squeeze_done && n_taken >= 300) begin
      squeeze_done = 1'b1;
      squeeze_left = 59;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm() && $urandom_range(99) < 9;
    end
  end

  function automatic cds_pkg::in_word_t random_word();
    cds_pkg::in_word_t w;
    w.cmd = 2'($urandom_range(3));
    w.elapsed = 8'($urandom_range(255));
    w.status_one = 1'($urandom_range(1));
    w.status_two = 1'($urandom_range(1));
    w.phase_a_level = 16'($urandom_range(65535));
    w.phase_b_level = 16'($urandom_range(65535));
    w.phase_c_level = 16'($urandom_range(65535));
    return w;
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return cfg_min + 16'($urandom_range(4)) - 16'd2;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic push_word(input logic [1:0] c, input logic [7:0] el, input logic s1,
                           input logic s2, input logic [15:0] pa, input logic [15:0] pb,
                           input logic [15:0] pc);
    pending.push_back({c, el, s1, s2, pa, pb, pc});
  endtask

  task automatic settle_down();
    while (pending.size() > 0 || in_valid || due_words.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      cds_pkg::REG_POLARITY:  cfg_pol = val[0];
      cds_pkg::REG_HOLD:      cfg_hold = val;
      cds_pkg::REG_TIMEOUT:   cfg_timeout = val;
      cds_pkg::REG_ALARM_DLY: cfg_alarm_dly = val;
      cds_pkg::REG_CONFIRM:   cfg_confirm = val;
      cds_pkg::REG_MIN_PHASE: cfg_min = val;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic load_settings(input logic pol, input logic [15:0] hold, input logic [15:0] tmo,
                               input logic [15:0] dly, input logic [15:0] conf,
                               input logic [15:0] minp);
    settle_down();
    write_reg(cds_pkg::REG_POLARITY, {15'd0, pol});
    write_reg(cds_pkg::REG_HOLD, hold);
    write_reg(cds_pkg::REG_TIMEOUT, tmo);
    write_reg(cds_pkg::REG_ALARM_DLY, dly);
    write_reg(cds_pkg::REG_CONFIRM, conf);
    write_reg(cds_pkg::REG_MIN_PHASE, minp);
  endtask

  // drive sequences: a command, then ticks whose contacts settle to the commanded
  // state, or stay stuck opposite so the alarm path runs; some noise in between
  task automatic run_phase(input int items, input int lo, input int hi,
                           input int el_max, input int stuck_pct);
    cds_pkg::in_word_t w;
    int count;
    int n;
    int settle;
    logic on_req;
    logic lvl_end;
    logic s;
    count = 0;
    while (count < items) begin
      if ($urandom_range(9) == 0) begin
        pending.push_back(random_word());
        count++;
      end
      on_req = 1'($urandom_range(1));
      lvl_end = (on_req ? cfg_pol : !cfg_pol) ^ ($urandom_range(99) < stuck_pct);
      w = random_word();
      w.cmd = on_req ? cds_pkg::CMD_ON : cds_pkg::CMD_OFF;
      pending.push_back(w);
      settle = $urandom_range(5);
      n = $urandom_range(hi, lo);
      for (int k = 0; k < n; k++) begin
        w = random_word();
        w.cmd = ($urandom_range(39) == 0) ? CMD_UNDEF : cds_pkg::CMD_TICK;
        w.elapsed = 8'($urandom_range(el_max));
        s = (k < settle) ? !lvl_end : lvl_end;
        w.status_one = s;
        w.status_two = ($urandom_range(11) == 0) ? !s : s;
        w.phase_a_level = pick_level();
        w.phase_b_level = pick_level();
        w.phase_c_level = pick_level();
        pending.push_back(w);
      end
      count += n + 1;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // defaults: idle mismatch, split readings, on and off sequences
    push_word(cds_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    push_word(cds_pkg::CMD_TICK, 8'd255, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(cds_pkg::CMD_TICK, 8'd0, 1'b1, 1'b0, 16'd700, 16'd700, 16'd700);
    push_word(CMD_UNDEF, 8'd255, 1'b1, 1'b1, 16'd699, 16'd0, 16'hFFFF);
    push_word(cds_pkg::CMD_TICK, 8'd255, 1'b1, 1'b1, 16'd1234, 16'd5678, 16'hFFFF);
    push_word(cds_pkg::CMD_ON, 8'd255, 1'b1, 1'b0, 16'h0000, 16'h0000, 16'h0000);
    push_word(cds_pkg::CMD_TICK, 8'd10, 1'b0, 1'b0, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd20, 1'b0, 1'b1, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd200, 1'b1, 1'b1, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd0, 1'b1, 1'b1, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd1, 1'b1, 1'b1, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_OFF, 8'd0, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    push_word(cds_pkg::CMD_TICK, 8'd3, 1'b0, 1'b0, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd255, 1'b0, 1'b0, 16'd800, 16'd800, 16'd800);

    // zero delays: reported raise while off, recover, raise held back by a low phase
    load_settings(1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'd700);
    push_word(cds_pkg::CMD_TICK, 8'd1, 1'b1, 1'b1, 16'd700, 16'd700, 16'd700);
    push_word(cds_pkg::CMD_TICK, 8'd7, 1'b0, 1'b0, 16'd700, 16'd700, 16'd700);
    push_word(cds_pkg::CMD_TICK, 8'd5, 1'b1, 1'b1, 16'd699, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd0, 1'b0, 1'b0, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_ON, 8'd0, 1'b0, 1'b0, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd0, 1'b1, 1'b1, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd0, 1'b1, 1'b1, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd0, 1'b1, 1'b1, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd0, 1'b1, 1'b0, 16'd800, 16'd800, 16'd800);
    push_word(cds_pkg::CMD_TICK, 8'd3, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'h0000);
    push_word(cds_pkg::CMD_OFF, 8'd0, 1'b1, 1'b1, 16'd800, 16'd800, 16'd800);

    load_settings(cds_pkg::RST_POLARITY, cds_pkg::RST_HOLD, cds_pkg::RST_TIMEOUT,
                  cds_pkg::RST_ALARM_DLY, cds_pkg::RST_CONFIRM, cds_pkg::RST_MIN_PHASE);
    run_phase(200, 2, 40, 255, 25);
    load_settings(1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_phase(200, 1, 12, 255, 25);
    load_settings(1'b1, 16'd8, 16'd40, 16'd12, 16'd20, 16'd500);
    run_phase(250, 2, 30, 15, 30);
    // all limits at maximum: long sequences saturate the sequence timer and wrap the mismatch time
    load_settings(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(200, 150, 300, 255, 50);
    load_settings(1'b0, 16'd30, 16'd200, 16'd60, 16'd100, 16'd1000);
    run_phase(250, 2, 40, 31, 30);

    settle_down();
    repeat (8) @(posedge clk);
    if (n_bad == 0 && due_words.size() == 0) begin
      $display("PASS contactor_drive_supervisor");
    end else begin
      $display("FAIL contactor_drive_supervisor");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL contactor_drive_supervisor");
    $finish;
  end

endmodule
`default_nettype wire
